### src/tlqe_pkg.sv
// ----------------------------------------------------------------------------
// tlqe_pkg
// Shared widths, constants and types for the thick line quad expander.
// ----------------------------------------------------------------------------
package tlqe_pkg;

  localparam int IN_W       = 16;  // input coordinate width, signed
  localparam int WIDTH_W    = 12;  // thickness width, unsigned
  localparam int RGBA_W     = 32;
  localparam int IDX_W      = 3;
  localparam int MAG_W      = 16;  // magnitude of an input difference
  localparam int KBITS      = 12;  // offset magnitude bits, result is 0 to 2048
  localparam int S_W        = 34;  // squared length
  localparam int LIM_W      = 56;  // squared scaled thickness
  localparam int ACC_W      = 64;  // cell accumulators, signed
  localparam int OFF_W      = 14;  // signed offset
  localparam int SUM_W      = 34;  // vertex sum before saturation
  localparam int IN_TDATA_W = 112; // 108 bits of fields, padded to bytes

  localparam int DEF_COORD_WIDTH = 16;

  localparam logic [IDX_W-1:0] VTX_FIRST = 3'd0;
  localparam logic [IDX_W-1:0] VTX_LAST  = 3'd5;

  typedef struct packed {
    logic signed [IN_W-1:0] sx;
    logic signed [IN_W-1:0] sy;
    logic signed [IN_W-1:0] ex;
    logic signed [IN_W-1:0] ey;
    logic [RGBA_W-1:0]      rgba;
    logic                   dy_pos;  // x offset takes the negative sign
    logic                   dx_neg;  // y offset takes the negative sign
  } pay_t;

  // One search lane: p = (2k-1)^2 * s, q = (2k-1) * s, limit and result bits.
  typedef struct packed {
    logic signed [ACC_W-1:0] p;
    logic signed [ACC_W-1:0] q;
    logic [LIM_W-1:0]        lim;
    logic [KBITS-1:0]        k;
  } lane_t;

  typedef struct packed {
    pay_t           pay;
    logic [S_W-1:0] s;
    lane_t          lx;
    lane_t          ly;
  } cell_t;

endpackage

### src/tlqe_front.sv
// ----------------------------------------------------------------------------
// tlqe_front
// Differences, products and squares that seed the search cells.
// ----------------------------------------------------------------------------
module tlqe_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tlqe_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tlqe_pkg::cell_t                 out_data
);

  logic signed [tlqe_pkg::IN_W-1:0] in_sx, in_sy, in_ex, in_ey;
  logic signed [tlqe_pkg::IN_W:0]   dx, dy;
  logic [tlqe_pkg::IN_W:0]          adx_full, ady_full;

  logic                              a_valid, b_valid, c_valid;
  logic                              a_ready, b_ready, c_ready;
  tlqe_pkg::pay_t                    a_pay, b_pay;
  logic [tlqe_pkg::MAG_W-1:0]        a_adx, a_ady;
  logic [tlqe_pkg::WIDTH_W-1:0]      a_w;
  logic [2*tlqe_pkg::MAG_W-1:0]      b_adx2, b_ady2;
  logic [tlqe_pkg::MAG_W+tlqe_pkg::WIDTH_W-1:0] b_awx, b_awy;
  logic [tlqe_pkg::S_W-1:0]          s_sum;

  assign in_sx = s_tdata[15:0];
  assign in_sy = s_tdata[31:16];
  assign in_ex = s_tdata[47:32];
  assign in_ey = s_tdata[63:48];

  assign dx = {in_ex[15], in_ex} - {in_sx[15], in_sx};
  assign dy = {in_ey[15], in_ey} - {in_sy[15], in_sy};
  assign adx_full = dx[16] ? -dx : dx;
  assign ady_full = dy[16] ? -dy : dy;

  assign c_ready  = !c_valid || out_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign s_tready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      // A segment of zero length is taken and dropped here.
      if (a_ready) a_valid <= s_tvalid && (dx != '0 || dy != '0);
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && s_tvalid) begin
      a_pay.sx     <= in_sx;
      a_pay.sy     <= in_sy;
      a_pay.ex     <= in_ex;
      a_pay.ey     <= in_ey;
      a_pay.rgba   <= s_tdata[107:76];
      a_pay.dy_pos <= !dy[16] && (dy != '0);
      a_pay.dx_neg <= dx[16];
      a_adx        <= adx_full[tlqe_pkg::MAG_W-1:0];
      a_ady        <= ady_full[tlqe_pkg::MAG_W-1:0];
      a_w          <= s_tdata[75:64];
    end
    if (b_ready && a_valid) begin
      b_pay  <= a_pay;
      b_adx2 <= a_adx * a_adx;
      b_ady2 <= a_ady * a_ady;
      b_awx  <= a_ady * a_w;
      b_awy  <= a_adx * a_w;
    end
    if (c_ready && b_valid) begin
      out_data.pay    <= b_pay;
      out_data.s      <= s_sum;
      out_data.lx.p   <= $signed({{(tlqe_pkg::ACC_W-tlqe_pkg::S_W){1'b0}}, s_sum});
      out_data.lx.q   <= -$signed({{(tlqe_pkg::ACC_W-tlqe_pkg::S_W){1'b0}}, s_sum});
      out_data.lx.lim <= b_awx * b_awx;
      out_data.lx.k   <= '0;
      out_data.ly.p   <= $signed({{(tlqe_pkg::ACC_W-tlqe_pkg::S_W){1'b0}}, s_sum});
      out_data.ly.q   <= -$signed({{(tlqe_pkg::ACC_W-tlqe_pkg::S_W){1'b0}}, s_sum});
      out_data.ly.lim <= b_awy * b_awy;
      out_data.ly.k   <= '0;
    end
  end

  assign s_sum = {2'b00, b_adx2} + {2'b00, b_ady2};
  assign out_valid = c_valid;

endmodule

### src/tlqe_cell.sv
// ----------------------------------------------------------------------------
// tlqe_cell
// One step of the offset search: decides result bit BIT for both lanes.
// ----------------------------------------------------------------------------
module tlqe_cell #(
  parameter int BIT = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tlqe_pkg::cell_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tlqe_pkg::cell_t out_data
);

  // Tries k + 2^BIT: (2c-1)^2 s = p + 2^(BIT+2) q + 2^(2BIT+2) s.
  function automatic tlqe_pkg::lane_t step(tlqe_pkg::lane_t l,
                                           logic [tlqe_pkg::S_W-1:0] s);
    tlqe_pkg::lane_t r;
    logic signed [tlqe_pkg::ACC_W-1:0] sv;
    logic signed [tlqe_pkg::ACC_W-1:0] pc;
    logic signed [tlqe_pkg::ACC_W-1:0] lv;
    logic capped;
    r  = l;
    sv = $signed({{(tlqe_pkg::ACC_W-tlqe_pkg::S_W){1'b0}}, s});
    lv = $signed({{(tlqe_pkg::ACC_W-tlqe_pkg::LIM_W){1'b0}}, l.lim});
    pc = l.p + (l.q <<< (2 + BIT)) + (sv <<< (2 + 2 * BIT));
    // Once the top bit is set the offset is at its ceiling of 2048.
    capped = (BIT < tlqe_pkg::KBITS - 1) && l.k[tlqe_pkg::KBITS-1];
    if (!capped && (pc <= lv)) begin
      r.p      = pc;
      r.q      = l.q + (sv <<< (1 + BIT));
      r.k[BIT] = 1'b1;
    end
    return r;
  endfunction

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.pay <= in_data.pay;
      out_data.s   <= in_data.s;
      out_data.lx  <= step(in_data.lx, in_data.s);
      out_data.ly  <= step(in_data.ly, in_data.s);
    end
  end

endmodule

### src/tlqe_emit.sv
// ----------------------------------------------------------------------------
// tlqe_emit
// Holds one finished segment and sends its six saturated vertices.
// ----------------------------------------------------------------------------
module tlqe_emit #(
  parameter int COORD_WIDTH = tlqe_pkg::DEF_COORD_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tlqe_pkg::cell_t                 in_data,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [((2*COORD_WIDTH+tlqe_pkg::RGBA_W+7)/8)*8-1:0] m_tdata,
  output logic [tlqe_pkg::IDX_W-1:0]      m_tuser,
  output logic                            m_tlast
);

  localparam logic signed [tlqe_pkg::SUM_W-1:0] SAT_HI =
    (34'sd1 <<< (COORD_WIDTH - 1)) - 34'sd1;
  localparam logic signed [tlqe_pkg::SUM_W-1:0] SAT_LO = -SAT_HI - 34'sd1;

  logic                               busy;
  logic [tlqe_pkg::IDX_W-1:0]         idx;
  tlqe_pkg::pay_t                     pay;
  logic signed [tlqe_pkg::OFF_W-1:0]  hx, hy;
  logic signed [tlqe_pkg::OFF_W-1:0]  magx, magy;
  logic                               use_end, plus;
  logic [COORD_WIDTH-1:0]             vx, vy;

  function automatic logic [COORD_WIDTH-1:0] place(
    logic signed [tlqe_pkg::IN_W-1:0] base, logic signed [tlqe_pkg::OFF_W-1:0] off,
    logic add);
    logic signed [tlqe_pkg::SUM_W-1:0] b;
    logic signed [tlqe_pkg::SUM_W-1:0] o;
    logic signed [tlqe_pkg::SUM_W-1:0] v;
    b = {{(tlqe_pkg::SUM_W-tlqe_pkg::IN_W){base[tlqe_pkg::IN_W-1]}}, base};
    o = {{(tlqe_pkg::SUM_W-tlqe_pkg::OFF_W){off[tlqe_pkg::OFF_W-1]}}, off};
    v = add ? b + o : b - o;
    if (v > SAT_HI) v = SAT_HI;
    else if (v < SAT_LO) v = SAT_LO;
    return v[COORD_WIDTH-1:0];
  endfunction

  assign in_ready = !busy || (m_tready && idx == tlqe_pkg::VTX_LAST);

  assign magx = {2'b00, in_data.lx.k};
  assign magy = {2'b00, in_data.ly.k};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= tlqe_pkg::VTX_FIRST;
    end else if (in_ready && in_valid) begin
      busy <= 1'b1;
      idx  <= tlqe_pkg::VTX_FIRST;
    end else if (busy && m_tready) begin
      if (idx == tlqe_pkg::VTX_LAST) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pay <= in_data.pay;
      hx  <= in_data.pay.dy_pos ? -magx : magx;
      hy  <= in_data.pay.dx_neg ? -magy : magy;
    end
  end

  // Order: start+h, start-h, end+h, end+h, start-h, end-h.
  always_comb begin
    case (idx) inside
      3'd0:       begin use_end = 1'b0; plus = 1'b1; end
      3'd1, 3'd4: begin use_end = 1'b0; plus = 1'b0; end
      3'd2, 3'd3: begin use_end = 1'b1; plus = 1'b1; end
      default:    begin use_end = 1'b1; plus = 1'b0; end
    endcase
  end

  assign vx = place(use_end ? pay.ex : pay.sx, hx, plus);
  assign vy = place(use_end ? pay.ey : pay.sy, hy, plus);

  always_comb begin
    m_tdata = '0;
    m_tdata[COORD_WIDTH-1:0]                 = vx;
    m_tdata[2*COORD_WIDTH-1:COORD_WIDTH]     = vy;
    m_tdata[2*COORD_WIDTH+tlqe_pkg::RGBA_W-1:2*COORD_WIDTH] = pay.rgba;
  end

  assign m_tvalid = busy;
  assign m_tuser  = idx;
  assign m_tlast  = (idx == tlqe_pkg::VTX_LAST);

endmodule

### src/thick_line_quad_expander.sv
// ----------------------------------------------------------------------------
// thick_line_quad_expander
// Expands a thick line segment into two triangles of six vertices.
// ----------------------------------------------------------------------------
// Each word on the slave channel is one segment: two endpoints, a thickness
// and a colour. For every segment of non-zero length the master channel sends
// six vertex words, start+h, start-h, end+h, end+h, start-h, end-h, where h
// is the half-thickness offset along the unit normal, rounded to nearest.
// tuser carries the vertex index and tlast marks the sixth vertex. A segment
// whose endpoints coincide is taken and produces no words at all.
//
// From acceptance to the first vertex, three front stages form the
// differences, products and squares, then a row of twelve search cells
// decides the offset one bit per cell, and then the emitter loads.
// The cells are pipelined, so a new segment may enter on every cycle while
// the row has room; the sustained rate is set by the emitter, sending one
// vertex per cycle on the single output channel while m_tready is high.
//
// Reset clears every valid flag; nothing else needs clearing. When the
// receiver stalls the emitter holds its vertex and the stall backs up
// through the cells one stage at a time, so s_tready falls only once every
// stage in the row is full.
// ----------------------------------------------------------------------------
module thick_line_quad_expander #(
  parameter int COORD_WIDTH = tlqe_pkg::DEF_COORD_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // start_x [15:0], start_y [31:16], end_x [47:32], end_y [63:48],
  // width [75:64], rgba [107:76], zero pad [111:108]
  input  logic [tlqe_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // vert_x, vert_y (COORD_WIDTH bits each), vert_rgba, zero pad to bytes
  output logic [((2*COORD_WIDTH+tlqe_pkg::RGBA_W+7)/8)*8-1:0] m_tdata,
  // vert_index [2:0]
  output logic [tlqe_pkg::IDX_W-1:0]      m_tuser,
  output logic                            m_tlast
);

  localparam int NCELL = tlqe_pkg::KBITS;

  // Stage n feeds cell n; stage NCELL feeds the emitter.
  logic            st_valid [NCELL+1];
  logic            st_ready [NCELL+1];
  tlqe_pkg::cell_t st_data  [NCELL+1];

  tlqe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .out_valid (st_valid[0]),
    .out_ready (st_ready[0]),
    .out_data  (st_data[0])
  );

  // Cells run from the top result bit down to bit zero.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    tlqe_cell #(
      .BIT (NCELL - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (st_valid[i]),
      .in_ready  (st_ready[i]),
      .in_data   (st_data[i]),
      .out_valid (st_valid[i+1]),
      .out_ready (st_ready[i+1]),
      .out_data  (st_data[i+1])
    );
  end

  tlqe_emit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (st_valid[NCELL]),
    .in_ready (st_ready[NCELL]),
    .in_data  (st_data[NCELL]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

### src/tlqe_checker.sv
// ----------------------------------------------------------------------------
// tlqe_checker
// Port-level checks on the vertex stream of the quad expander.
// ----------------------------------------------------------------------------
module tlqe_checker #(
  parameter int COORD_WIDTH = tlqe_pkg::DEF_COORD_WIDTH
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [((2*COORD_WIDTH+tlqe_pkg::RGBA_W+7)/8)*8-1:0] m_tdata,
  input logic [tlqe_pkg::IDX_W-1:0] m_tuser,
  input logic                       m_tlast
);

  // The last flag sits on the sixth vertex and nowhere else.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == tlqe_pkg::VTX_LAST)))
    else $error("tlast does not match vertex index");

  // Within a run the vertices follow without gaps and in order.
  a_run_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && m_tuser == $past(m_tuser) + 3'd1))
    else $error("vertex run broken or out of order");

  // A stalled vertex holds its data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled vertex changed");

  // Reset empties the output.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind thick_line_quad_expander tlqe_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_tlqe_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
